// ----- rtl/spfu_pkg.sv -----
package spfu_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] EXP_BITS  = 32'h7F80_0000;
  localparam logic [31:0] FRAC_BITS = 32'h007F_FFFF;
  localparam logic signed [11:0] BIAS    = 12'sd127;
  localparam logic signed [11:0] EXP_MAX = 12'sd255;

  localparam int MW       = 57;  // working mantissa, leading one at bit 56 or below (mul: 55 or 56)
  localparam int QW       = 28;  // quotient bits
  localparam int DIV_BITS = 4;   // quotient bits per pipeline stage
  localparam int NSTG     = 10;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_I2F = 4'd4;
  localparam logic [3:0] OP_F2I = 4'd5;
  localparam logic [3:0] OP_EQ  = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_LE  = 4'd8;
  localparam logic [3:0] OP_GT  = 4'd9;
  localparam logic [3:0] OP_GE  = 4'd10;
  localparam logic [3:0] OP_UN  = 4'd11;

  typedef enum logic [1:0] {C_ZERO, C_FIN, C_INF, C_NAN} cls_e;
  typedef enum logic [1:0] {K_ADD, K_MUL, K_DIV, K_CVT} kind_e;

  typedef struct packed {
    logic             neg;
    logic signed [11:0] e;
    logic [23:0]      m;
    cls_e             cls;
  } unp_t;

  typedef struct packed {
    logic               special;
    logic [31:0]        val;
    kind_e              kind;
    logic               neg;
    logic signed [11:0] e;
    logic [MW-1:0]      ma;
    logic [MW-1:0]      mb;
    logic               eff_sub;
    logic [23:0]        xm;
    logic [23:0]        ym;
    logic signed [11:0] ye;
    logic               yneg;
    logic [24:0]        rem;
    logic [QW-1:0]      quo;
  } stage_t;

  function automatic unp_t unpack(input logic [31:0] x);
    unp_t       u;
    logic [4:0] lz;
    logic       found;
    u.neg = x[31];
    u.e   = 12'($unsigned(x[30:23]));
    u.m   = {1'b1, x[22:0]};
    lz    = '0;
    found = 1'b0;
    if (x[30:23] == 8'hFF) begin
      u.cls = (x[22:0] != '0) ? C_NAN : C_INF;
    end else if (x[30:23] != '0) begin
      u.cls = C_FIN;
    end else if (x[22:0] == '0) begin
      u.cls = C_ZERO;
    end else begin
      for (int i = 22; i >= 0; i--) begin
        if (!found && x[i]) begin
          found = 1'b1;
          lz    = 5'(22 - i);
        end
      end
      // subnormal: leading one moved to bit 23
      u.m   = 24'({x[22:0], 1'b0} << lz);
      u.e   = -$signed(12'($unsigned(lz)));
      u.cls = C_FIN;
    end
    return u;
  endfunction

  // m: leading one at bit 26, bits 2..0 guard, round, sticky
  function automatic logic [31:0] pack_rounded(input logic neg, input logic signed [11:0] e,
                                               input logic [26:0] m);
    logic               tiny;
    logic [11:0]        sh;
    logic [4:0]         shc;
    logic [26:0]        mm;
    logic [26:0]        shr;
    logic [24:0]        frac;
    logic [2:0]         r;
    logic signed [11:0] e1;
    logic [30:0]        body;
    tiny = (e <= 12'sd0);
    mm   = m;
    e1   = e;
    if (tiny) begin
      sh  = 12'(12'sd1 - e);
      shc = (sh > 12'd27) ? 5'd27 : sh[4:0];
      shr = mm >> shc;
      mm  = shr | 27'(((shr << shc) != mm) ? 1 : 0);
    end
    frac = {1'b0, mm[26:3]};
    r    = mm[2:0];
    if (r > 3'd4 || (r == 3'd4 && frac[0])) begin
      frac = frac + 25'd1;
    end
    if (frac[24]) begin
      frac = frac >> 1;
      e1   = e + 12'sd1;
    end
    body = {e1[7:0] - 8'd1, 23'b0} + {6'b0, frac};
    if (e >= EXP_MAX || (!tiny && e1 >= EXP_MAX)) begin
      return {neg, EXP_BITS[30:0]};
    end else if (tiny) begin
      return {neg, 6'b0, frac};
    end else begin
      return {neg, body};
    end
  endfunction

endpackage

// ----- rtl/spfu_if.sv -----
interface spfu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source(output valid, op, operand_a, operand_b, input ready);
  modport sink(input valid, op, operand_a, operand_b, output ready);
endinterface

interface spfu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  modport source(output valid, result, input ready);
  modport sink(input valid, result, output ready);
endinterface

// ----- rtl/spfu_div_step.sv -----
module spfu_div_step (
  input  logic [24:0]            rem_i,
  input  logic [spfu_pkg::QW-1:0] quo_i,
  input  logic [23:0]            dvs_i,
  output logic [24:0]            rem_o,
  output logic [spfu_pkg::QW-1:0] quo_o
);
  import spfu_pkg::*;

  // restoring division, DIV_BITS quotient bits msb first
  always_comb begin
    logic [24:0]   r;
    logic [QW-1:0] q;
    r = rem_i;
    q = quo_i;
    for (int i = 0; i < DIV_BITS; i++) begin
      if (r >= {1'b0, dvs_i}) begin
        r = r - {1'b0, dvs_i};
        q = {q[QW-2:0], 1'b1};
      end else begin
        q = {q[QW-2:0], 1'b0};
      end
      r = {r[23:0], 1'b0};
    end
    rem_o = r;
    quo_o = q;
  end

endmodule

// ----- rtl/single_precision_float_unit.sv -----
// Binary32 add/sub/mul/div, int conversions and compares, round to nearest even
// (float to int truncates). Stages: unpack, 7 divider stages (4 quotient bits
// per stage), normalize, round and pack. Throughput: one request per cycle for
// every op unless the output stalls; a stall holds each valid stage in place.
// Reset clears the stage valid bits only; data registers are not reset.
module single_precision_float_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  spfu_req_if.sink   req_i,
  spfu_rsp_if.source rsp_o
);
  import spfu_pkg::*;

  stage_t s_q [NSTG];
  stage_t s_d [NSTG];
  logic   v_q [NSTG];
  logic   adv [NSTG];

  // ---------------- stage 0: unpack, specials, compares, f2i
  always_comb begin
    stage_t             s;
    unp_t               x, y;
    logic               nan_a, nan_b, bz, eq, lt_ab, lt_ba;
    logic [31:0]        ka, kb, mag, a, b;
    logic signed [11:0] u;
    logic               yneg;
    a = req_i.operand_a;
    b = req_i.operand_b;
    x = unpack(a);
    y = unpack(b);
    s = '0;
    s.kind    = K_ADD;
    s.special = 1'b1;
    s.val     = '0;
    s.neg     = x.neg;
    s.e       = x.e;
    s.xm      = x.m;
    s.ym      = y.m;
    s.ye      = y.e;
    nan_a = (x.cls == C_NAN);
    nan_b = (y.cls == C_NAN);
    bz    = (a[30:0] == '0) && (b[30:0] == '0);
    ka    = a[31] ? ~a : (a | SIGN_BIT);
    kb    = b[31] ? ~b : (b | SIGN_BIT);
    eq    = !nan_a && !nan_b && (a == b || bz);
    lt_ab = !nan_a && !nan_b && !bz && (ka < kb);
    lt_ba = !nan_a && !nan_b && !bz && (kb < ka);
    yneg  = y.neg ^ (req_i.op == OP_SUB);
    u     = x.e - BIAS;
    mag   = '0;
    case (req_i.op)
      OP_ADD, OP_SUB: begin
        s.yneg = yneg;
        if (nan_a || nan_b) begin
          s.val = QNAN_BITS;
        end else if (x.cls == C_INF || y.cls == C_INF) begin
          if (x.cls == C_INF && y.cls == C_INF && x.neg != yneg) s.val = QNAN_BITS;
          else if (x.cls == C_INF) s.val = a;
          else s.val = {yneg, EXP_BITS[30:0]};
        end else if (x.cls == C_ZERO && y.cls == C_ZERO) begin
          s.val = (x.neg && yneg) ? SIGN_BIT : '0;
        end else if (y.cls == C_ZERO) begin
          s.val = a;
        end else if (x.cls == C_ZERO) begin
          s.val = {yneg, b[30:0]};
        end else begin
          s.special = 1'b0;
        end
      end
      OP_MUL: begin
        s.kind = K_MUL;
        s.neg  = x.neg ^ y.neg;
        s.e    = x.e + y.e - BIAS;
        if (nan_a || nan_b) s.val = QNAN_BITS;
        else if (x.cls == C_INF || y.cls == C_INF) begin
          s.val = (x.cls == C_ZERO || y.cls == C_ZERO) ? QNAN_BITS : {s.neg, EXP_BITS[30:0]};
        end else if (x.cls == C_ZERO || y.cls == C_ZERO) s.val = {s.neg, 31'b0};
        else s.special = 1'b0;
      end
      OP_DIV: begin
        s.kind = K_DIV;
        s.neg  = x.neg ^ y.neg;
        s.e    = x.e - y.e + BIAS;
        s.rem  = {1'b0, x.m};
        if (nan_a || nan_b) s.val = QNAN_BITS;
        else if (y.cls == C_ZERO) begin
          s.val = (x.cls == C_ZERO) ? QNAN_BITS : {s.neg, EXP_BITS[30:0]};
        end else if (y.cls == C_INF) begin
          s.val = (x.cls == C_INF) ? QNAN_BITS : {s.neg, 31'b0};
        end else if (x.cls == C_INF) s.val = {s.neg, EXP_BITS[30:0]};
        else if (x.cls == C_ZERO) s.val = {s.neg, 31'b0};
        else s.special = 1'b0;
      end
      OP_I2F: begin
        s.kind = K_CVT;
        s.neg  = a[31];
        s.e    = BIAS + 12'sd31;
        mag    = a[31] ? (32'd0 - a) : a;
        s.ma   = {1'b0, mag, 24'b0};
        if (a != '0) s.special = 1'b0;
      end
      OP_F2I: begin
        if (x.cls == C_NAN || x.cls == C_INF) s.val = SIGN_BIT;
        else if (x.cls == C_ZERO || u < 12'sd0) s.val = '0;
        else if (u >= 12'sd31) s.val = SIGN_BIT;
        else begin
          if (u >= 12'sd23) mag = {8'b0, x.m} << 5'(u - 12'sd23);
          else mag = {8'b0, x.m} >> 5'(12'sd23 - u);
          s.val = x.neg ? (32'd0 - mag) : mag;
        end
      end
      OP_EQ: s.val = {31'b0, eq};
      OP_LT: s.val = {31'b0, lt_ab};
      OP_LE: s.val = {31'b0, lt_ab | eq};
      OP_GT: s.val = {31'b0, lt_ba};
      OP_GE: s.val = {31'b0, lt_ba | eq};
      OP_UN: s.val = {31'b0, nan_a | nan_b};
      default: s.val = '0;
    endcase
    s_d[0] = s;
  end

  // ---------------- stages 1..7: divider, plus add align/multiply and add
  for (genvar k = 1; k < 8; k++) begin : g_mid
    logic [24:0]   rem_n;
    logic [QW-1:0] quo_n;

    spfu_div_step u_div (
      .rem_i (s_q[k-1].rem),
      .quo_i (s_q[k-1].quo),
      .dvs_i (s_q[k-1].ym),
      .rem_o (rem_n),
      .quo_o (quo_n)
    );

    always_comb begin
      stage_t             s;
      logic               swap;
      logic [23:0]        bm, sm;
      logic signed [11:0] be, se, d;
      logic               bneg, sneg;
      logic [5:0]         dsh;
      logic [55:0]        mbw, shr;
      s = s_q[k-1];
      if (s.kind == K_DIV) begin
        s.rem = rem_n;
        s.quo = quo_n;
      end
      swap = (s.ye > s.e) || (s.ye == s.e && s.ym > s.xm);
      bm   = swap ? s.ym : s.xm;
      sm   = swap ? s.xm : s.ym;
      be   = swap ? s.ye : s.e;
      se   = swap ? s.e : s.ye;
      bneg = swap ? s.yneg : s.neg;
      sneg = swap ? s.neg : s.yneg;
      d    = be - se;
      dsh  = (d > 12'sd63) ? 6'd63 : d[5:0];
      mbw  = {sm, 32'b0};
      shr  = mbw >> dsh;
      if (k == 1) begin
        if (s.kind == K_ADD) begin
          s.ma      = {1'b0, bm, 32'b0};
          s.mb      = {1'b0, shr | 56'(((shr << dsh) != mbw) ? 1 : 0)};
          s.e       = be;
          s.neg     = bneg;
          s.eff_sub = bneg != sneg;
        end else if (s.kind == K_MUL) begin
          s.ma = {48'(s.xm) * 48'(s.ym), 9'b0};
        end
      end
      if (k == 2 && s.kind == K_ADD) begin
        if (!s.eff_sub) s.ma = s.ma + s.mb;
        else begin
          if (s.ma == s.mb && !s.special) begin
            s.special = 1'b1;
            s.val     = '0;
          end
          s.ma = s.ma - s.mb;
        end
      end
      s_d[k] = s;
    end
  end

  // ---------------- stage 8: normalize to 27 bits with sticky
  always_comb begin
    stage_t      s;
    logic [MW-1:0] mant, norm;
    logic [5:0]  lz;
    logic        found;
    s = s_q[7];
    if (s.kind == K_DIV) begin
      mant = {1'b0, s.quo[QW-1:1], s.quo[0] | (s.rem != '0), 28'b0};
    end else begin
      mant = s.ma;
    end
    lz    = '0;
    found = 1'b0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (!found && mant[i]) begin
        found = 1'b1;
        lz    = 6'(MW - 1 - i);
      end
    end
    norm   = mant << lz;
    s.ma   = {30'b0, norm[56:31], norm[30] | (norm[29:0] != '0)};
    s.e    = s.e + 12'sd1 - $signed(12'($unsigned(lz)));
    s_d[8] = s;
  end

  // ---------------- stage 9: round and pack
  always_comb begin
    stage_t s;
    s = s_q[8];
    if (!s.special) begin
      s.val = pack_rounded(s.neg, s.e, s.ma[26:0]);
    end
    s_d[9] = s;
  end

  // ---------------- pipeline control
  always_comb begin
    adv[NSTG-1] = !v_q[NSTG-1] || rsp_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign req_i.ready  = adv[0];
  assign rsp_o.valid  = v_q[NSTG-1];
  assign rsp_o.result = s_q[NSTG-1].val;

  for (genvar k = 0; k < NSTG; k++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= (k == 0) ? req_i.valid : v_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        s_q[k] <= s_d[k];
      end
    end
  end

endmodule
